// File: rtl/bftl_pkg.sv
// ----------------------------------------------------------------------------
// bftl_pkg: shared types and constants for the bitmap font text layout
// Holds depths, character codes, register indexes, the sequencer states and
// the structs that travel between the modules.
// ----------------------------------------------------------------------------
package bftl_pkg;

  // storage depths and address widths
  localparam int unsigned TEXT_DEPTH  = 64;
  localparam int unsigned ALPHA_DEPTH = 128;
  localparam int unsigned TXT_AW      = $clog2(TEXT_DEPTH);
  localparam int unsigned ALPHA_AW    = $clog2(ALPHA_DEPTH);

  // quotient bits of the atlas row/column divider
  localparam int unsigned DIV_STEPS   = 7;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;

  // input word kinds (tuser)
  localparam logic OP_TABLE = 1'b0;
  localparam logic OP_TEXT  = 1'b1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_GLYPH_W   = 2'd0;
  localparam logic [1:0] REG_GLYPH_H   = 2'd1;
  localparam logic [1:0] REG_ATLAS_COL = 2'd2;
  localparam logic [1:0] REG_ALPHA_LEN = 2'd3;

  // register reset values
  localparam logic [7:0] RST_GLYPH_W   = 8'd8;
  localparam logic [7:0] RST_GLYPH_H   = 8'd8;
  localparam logic [7:0] RST_ATLAS_COL = 8'd16;
  localparam logic [7:0] RST_ALPHA_LEN = 8'd0;

  // alignment flag bits
  localparam int unsigned AL_HCENTER = 0;
  localparam int unsigned AL_RIGHT   = 1;
  localparam int unsigned AL_VCENTER = 2;
  localparam int unsigned AL_BOTTOM  = 3;

  typedef struct packed {
    logic [7:0] glyph_width;
    logic [7:0] glyph_height;
    logic [7:0] atlas_columns;
    logic [7:0] alphabet_length;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [6:0]         table_slot;
    logic [7:0]         char_code;
    logic               final_char;
    logic signed [15:0] anchor_x;
    logic signed [15:0] anchor_y;
    logic [3:0]         align_flags;
  } item_t;

  typedef struct packed {
    logic signed [16:0] dest_x;
    logic signed [16:0] dest_y;
    logic [15:0]        source_x;
    logic [15:0]        source_y;
    logic               not_found;
    logic               last_glyph;
  } glyph_t;

  typedef struct packed {
    logic                start;
    logic [ALPHA_AW-1:0] dividend;
    logic [7:0]          divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [ALPHA_AW-1:0] quot;
    logic [7:0]          rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_TW,
    ST_TH,
    ST_TY,
    ST_TXT_RD,
    ST_TXT_CHK,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_DIV,
    ST_MCOL,
    ST_MROW,
    ST_EMIT
  } layout_state_e;

endpackage

// File: rtl/bftl_cfg.sv
// ----------------------------------------------------------------------------
// bftl_cfg: configuration registers
// APB-style register file for glyph size, atlas columns and alphabet length.
// ----------------------------------------------------------------------------
module bftl_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output bftl_pkg::cfg_t      cfg_o
);

  bftl_pkg::cfg_t cfg_q;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // register writes in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width     <= bftl_pkg::RST_GLYPH_W;
      cfg_q.glyph_height    <= bftl_pkg::RST_GLYPH_H;
      cfg_q.atlas_columns   <= bftl_pkg::RST_ATLAS_COL;
      cfg_q.alphabet_length <= bftl_pkg::RST_ALPHA_LEN;
    end else if (wr_en) begin
      case (paddr[3:2])
        bftl_pkg::REG_GLYPH_W:   cfg_q.glyph_width     <= pwdata[7:0];
        bftl_pkg::REG_GLYPH_H:   cfg_q.glyph_height    <= pwdata[7:0];
        bftl_pkg::REG_ATLAS_COL: cfg_q.atlas_columns   <= pwdata[7:0];
        bftl_pkg::REG_ALPHA_LEN: cfg_q.alphabet_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      bftl_pkg::REG_GLYPH_W:   prdata = {24'd0, cfg_q.glyph_width};
      bftl_pkg::REG_GLYPH_H:   prdata = {24'd0, cfg_q.glyph_height};
      bftl_pkg::REG_ATLAS_COL: prdata = {24'd0, cfg_q.atlas_columns};
      bftl_pkg::REG_ALPHA_LEN: prdata = {24'd0, cfg_q.alphabet_length};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/bftl_div.sv
// ----------------------------------------------------------------------------
// bftl_div: iterative restoring divider
// Splits an alphabet index into atlas row (quotient) and column (remainder),
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bftl_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bftl_pkg::div_req_t req_i,
  output bftl_pkg::div_rsp_t rsp_o
);

  localparam int unsigned QW = bftl_pkg::ALPHA_AW;
  localparam int unsigned CW = $clog2(bftl_pkg::DIV_STEPS + 1);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [7:0]    dvs_q;
  logic [7:0]    rem_q;
  logic [QW-1:0] quo_q;
  logic [8:0]    trial;
  logic          fits;

  // one trial subtraction per step
  assign trial = {rem_q, quo_q[QW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(bftl_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= 8'(trial - {1'b0, dvs_q});
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= trial[7:0];
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// File: rtl/bftl_layout.sv
// ----------------------------------------------------------------------------
// bftl_layout: text buffer, alphabet table and layout sequencer
// Loads characters and table entries, then aligns the text box and walks the
// buffer, searching the alphabet one entry per step with one shared multiplier.
// ----------------------------------------------------------------------------
module bftl_layout (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bftl_pkg::cfg_t     cfg_i,
  input  bftl_pkg::item_t    item_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  output bftl_pkg::glyph_t   glyph_o,
  output logic               glyph_valid_o,
  input  logic               glyph_ready_i,
  output bftl_pkg::div_req_t div_req_o,
  input  bftl_pkg::div_rsp_t div_rsp_i
);

  localparam int unsigned TAW = bftl_pkg::TXT_AW;
  localparam int unsigned AAW = bftl_pkg::ALPHA_AW;

  // memories
  logic [7:0] txt_mem   [bftl_pkg::TEXT_DEPTH];
  logic [7:0] alpha_mem [bftl_pkg::ALPHA_DEPTH];
  logic [7:0] txt_rd_q, alpha_rd_q;

  bftl_pkg::layout_state_e state_q, state_d;

  // control state
  logic [TAW:0]   count_q;
  logic [6:0]     lines_q, cur_q, widest_q;
  logic [TAW-1:0] last_idx_q;
  logic [TAW:0]   idx_q;
  logic [AAW:0]   k_q;

  // payload state
  logic signed [17:0] x_q, y_q, sx_q;
  logic signed [15:0] ax_q, ay_q;
  logic [3:0]         align_q;
  logic [7:0]         char_q;
  logic               nf_q;
  logic [15:0]        prod_q, srcx_q;

  // load helpers
  logic        acc, acc_text, buf_room, is_nl, draw_ch;
  logic [6:0]  lines_n, cur_n, wid_n, wid_fin;

  // walk helpers
  logic [AAW:0] alen;
  logic [7:0]   cols;
  logic         match, txt_end, alpha_end;

  // shared multiplier
  logic [7:0]  mul_a, mul_b;
  logic        mul_en;
  logic [15:0] prod_d;
  logic [15:0] shift_sub;

  function automatic logic signed [16:0] sat17(input logic signed [17:0] v);
    if (!v[17] && v[16])      sat17 = 17'sh0FFFF;
    else if (v[17] && !v[16]) sat17 = 17'sh10000;
    else                      sat17 = v[16:0];
  endfunction

  assign acc      = item_valid_i & item_ready_o;
  assign acc_text = acc & (item_i.op == bftl_pkg::OP_TEXT);
  assign buf_room = count_q < (TAW+1)'(bftl_pkg::TEXT_DEPTH);
  assign is_nl    = item_i.char_code == bftl_pkg::CH_NEWLINE;
  assign draw_ch  = !is_nl && (item_i.char_code != bftl_pkg::CH_SPACE);

  // line and width counting for one stored character
  always_comb begin
    lines_n = lines_q;
    cur_n   = cur_q;
    wid_n   = widest_q;
    if (buf_room) begin
      if (is_nl) begin
        lines_n = lines_q + 1'b1;
        cur_n   = '0;
        if (cur_q > widest_q) wid_n = cur_q;
      end else begin
        cur_n = cur_q + 1'b1;
      end
    end
    wid_fin = (cur_n > wid_n) ? cur_n : wid_n;
  end

  assign alen = (cfg_i.alphabet_length > 8'(bftl_pkg::ALPHA_DEPTH)) ?
                (AAW+1)'(bftl_pkg::ALPHA_DEPTH) : (AAW+1)'(cfg_i.alphabet_length);
  assign cols      = (cfg_i.atlas_columns == 8'd0) ? 8'd1 : cfg_i.atlas_columns;
  assign match     = alpha_rd_q == char_q;
  assign txt_end   = idx_q == count_q;
  assign alpha_end = k_q == alen;
  assign prod_d    = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bftl_pkg::ST_LOAD:
        if (acc_text && item_i.final_char) state_d = bftl_pkg::ST_TW;
      bftl_pkg::ST_TW:     state_d = bftl_pkg::ST_TH;
      bftl_pkg::ST_TH:     state_d = bftl_pkg::ST_TY;
      bftl_pkg::ST_TY:     state_d = bftl_pkg::ST_TXT_RD;
      bftl_pkg::ST_TXT_RD:
        state_d = txt_end ? bftl_pkg::ST_LOAD : bftl_pkg::ST_TXT_CHK;
      bftl_pkg::ST_TXT_CHK:
        if (txt_rd_q == bftl_pkg::CH_NEWLINE || txt_rd_q == bftl_pkg::CH_SPACE)
          state_d = bftl_pkg::ST_TXT_RD;
        else
          state_d = bftl_pkg::ST_SRCH_RD;
      bftl_pkg::ST_SRCH_RD:
        state_d = alpha_end ? bftl_pkg::ST_EMIT : bftl_pkg::ST_SRCH_CHK;
      bftl_pkg::ST_SRCH_CHK:
        state_d = match ? bftl_pkg::ST_DIV : bftl_pkg::ST_SRCH_RD;
      bftl_pkg::ST_DIV:
        if (div_rsp_i.done) state_d = bftl_pkg::ST_MCOL;
      bftl_pkg::ST_MCOL:   state_d = bftl_pkg::ST_MROW;
      bftl_pkg::ST_MROW:   state_d = bftl_pkg::ST_EMIT;
      bftl_pkg::ST_EMIT:
        if (glyph_ready_i) state_d = bftl_pkg::ST_TXT_RD;
      default:             state_d = bftl_pkg::ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_ready_o       = 1'b0;
    glyph_valid_o      = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = k_q[AAW-1:0];
    div_req_o.divisor  = cols;
    mul_en             = 1'b0;
    mul_a              = 8'd0;
    mul_b              = 8'd0;
    case (state_q)
      bftl_pkg::ST_LOAD:     item_ready_o = 1'b1;
      bftl_pkg::ST_TW: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, widest_q};
        mul_b  = cfg_i.glyph_width;
      end
      bftl_pkg::ST_TH: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, lines_q};
        mul_b  = cfg_i.glyph_height;
      end
      bftl_pkg::ST_SRCH_CHK: div_req_o.start = match;
      bftl_pkg::ST_MCOL: begin
        mul_en = 1'b1;
        mul_a  = div_rsp_i.rem;
        mul_b  = cfg_i.glyph_width;
      end
      bftl_pkg::ST_MROW: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, div_rsp_i.quot};
        mul_b  = cfg_i.glyph_height;
      end
      bftl_pkg::ST_EMIT:     glyph_valid_o = 1'b1;
      default: ;
    endcase
  end

  // glyph command fields
  assign glyph_o.dest_x     = sat17(x_q);
  assign glyph_o.dest_y     = sat17(y_q);
  assign glyph_o.source_x   = nf_q ? 16'd0 : srcx_q;
  assign glyph_o.source_y   = nf_q ? 16'd0 : prod_q;
  assign glyph_o.not_found  = nf_q;
  assign glyph_o.last_glyph = idx_q[TAW-1:0] == last_idx_q;

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (acc_text && buf_room) txt_mem[count_q[TAW-1:0]] <= item_i.char_code;
    if (state_q == bftl_pkg::ST_TXT_RD) txt_rd_q <= txt_mem[idx_q[TAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (acc && item_i.op == bftl_pkg::OP_TABLE)
      alpha_mem[item_i.table_slot[AAW-1:0]] <= item_i.char_code;
    if (state_q == bftl_pkg::ST_SRCH_RD) alpha_rd_q <= alpha_mem[k_q[AAW-1:0]];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bftl_pkg::ST_LOAD;
      count_q    <= '0;
      lines_q    <= 7'd1;
      cur_q      <= '0;
      widest_q   <= '0;
      last_idx_q <= '0;
      idx_q      <= '0;
      k_q        <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        bftl_pkg::ST_LOAD:
          if (acc_text) begin
            lines_q  <= lines_n;
            cur_q    <= cur_n;
            widest_q <= item_i.final_char ? wid_fin : wid_n;
            if (buf_room) begin
              count_q <= count_q + 1'b1;
              if (draw_ch) last_idx_q <= count_q[TAW-1:0];
            end
          end
        bftl_pkg::ST_TY: idx_q <= '0;
        bftl_pkg::ST_TXT_RD:
          if (txt_end) begin
            count_q  <= '0;
            lines_q  <= 7'd1;
            cur_q    <= '0;
            widest_q <= '0;
          end
        bftl_pkg::ST_TXT_CHK: begin
          k_q <= '0;
          if (txt_rd_q == bftl_pkg::CH_NEWLINE || txt_rd_q == bftl_pkg::CH_SPACE)
            idx_q <= idx_q + 1'b1;
        end
        bftl_pkg::ST_SRCH_CHK:
          if (!match) k_q <= k_q + 1'b1;
        bftl_pkg::ST_EMIT:
          if (glyph_ready_i) idx_q <= idx_q + 1'b1;
        default: ;
      endcase
    end
  end

  // alignment offset: full or half of the box size
  always_comb begin
    shift_sub = 16'd0;
    if (state_q == bftl_pkg::ST_TH) begin
      if (align_q[bftl_pkg::AL_HCENTER])    shift_sub = {1'b0, prod_q[15:1]};
      else if (align_q[bftl_pkg::AL_RIGHT]) shift_sub = prod_q;
    end else begin
      if (align_q[bftl_pkg::AL_VCENTER])     shift_sub = {1'b0, prod_q[15:1]};
      else if (align_q[bftl_pkg::AL_BOTTOM]) shift_sub = prod_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= prod_d;
    case (state_q)
      bftl_pkg::ST_LOAD:
        if (acc_text && item_i.final_char) begin
          ax_q    <= item_i.anchor_x;
          ay_q    <= item_i.anchor_y;
          align_q <= item_i.align_flags;
        end
      bftl_pkg::ST_TH:
        x_q <= 18'(ax_q) - $signed({2'b00, shift_sub});
      bftl_pkg::ST_TY: begin
        y_q  <= 18'(ay_q) - $signed({2'b00, shift_sub});
        sx_q <= x_q;
      end
      bftl_pkg::ST_TXT_CHK: begin
        char_q <= txt_rd_q;
        if (txt_rd_q == bftl_pkg::CH_NEWLINE) begin
          y_q <= y_q + $signed({10'd0, cfg_i.glyph_height});
          x_q <= sx_q;
        end else if (txt_rd_q == bftl_pkg::CH_SPACE) begin
          x_q <= x_q + $signed({10'd0, cfg_i.glyph_width});
        end
      end
      bftl_pkg::ST_SRCH_RD:
        if (alpha_end) nf_q <= 1'b1;
      bftl_pkg::ST_SRCH_CHK:
        if (match) nf_q <= 1'b0;
      bftl_pkg::ST_MROW: srcx_q <= prod_q;
      bftl_pkg::ST_EMIT:
        if (glyph_ready_i) x_q <= x_q + $signed({10'd0, cfg_i.glyph_width});
      default: ;
    endcase
  end

endmodule

// File: rtl/bitmap_font_text_layout.sv
// ----------------------------------------------------------------------------
// bitmap_font_text_layout: bitmap font text layout engine
// Stream in alphabet entries and text, stream out one blit command per glyph.
// ----------------------------------------------------------------------------
// Alphabet writes (tuser 0) and text characters (tuser 1) are taken one word
// per cycle. The word with tlast set ends the text and carries anchor and
// alignment; the input then stalls while the sequencer lays out the text:
// box alignment in states ST_TW, ST_TH and ST_TY, a read and check of each
// stored character, and for a drawn glyph a read and compare of each
// alphabet entry scanned up to its first match, the seven-step row/column
// divider, the column and row multiplies and the output register; a missing
// glyph scans the whole alphabet and goes straight to the output. The linear
// alphabet scan through its single memory read port sets the per-glyph time.
// Output stalls add directly. Text beyond 64 characters is dropped; the text
// state clears after the last command.
module bitmap_font_text_layout (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [6:0] table_slot, [14:7] char_code, [30:15] anchor_x, [46:31] anchor_y,
  // [50:47] align_flags, [55:51] zero
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // [0] op
  input  logic        s_axis_tlast,   // final_char
  // glyph commands
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [16:0] dest_x, [33:17] dest_y, [49:34] source_x, [65:50] source_y,
  // [71:66] zero
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] not_found
  output logic        m_axis_tlast    // last_glyph
);

  bftl_pkg::cfg_t     cfg;
  bftl_pkg::item_t    item;
  bftl_pkg::glyph_t   glyph, out_q;
  bftl_pkg::div_req_t div_req;
  bftl_pkg::div_rsp_t div_rsp;
  logic               glyph_valid, out_free, out_valid_q;

  // unpack input word
  assign item.op          = s_axis_tuser;
  assign item.table_slot  = s_axis_tdata[6:0];
  assign item.char_code   = s_axis_tdata[14:7];
  assign item.final_char  = s_axis_tlast;
  assign item.anchor_x    = s_axis_tdata[30:15];
  assign item.anchor_y    = s_axis_tdata[46:31];
  assign item.align_flags = s_axis_tdata[50:47];

  bftl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bftl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bftl_layout u_layout (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_i        (item),
    .item_valid_i  (s_axis_tvalid),
    .item_ready_o  (s_axis_tready),
    .glyph_o       (glyph),
    .glyph_valid_o (glyph_valid),
    .glyph_ready_i (out_free),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp)
  );

  // output register
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= glyph_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && glyph_valid) out_q <= glyph;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.source_y, out_q.source_x,
                          out_q.dest_y, out_q.dest_x};
  assign m_axis_tuser  = out_q.not_found;
  assign m_axis_tlast  = out_q.last_glyph;

endmodule

// File: rtl/bftl_checker.sv
// ----------------------------------------------------------------------------
// bftl_checker: port-level assertions for the text layout block
// Watches the streams and flags slips in command sequencing.
// ----------------------------------------------------------------------------
module bftl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled command stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("glyph command dropped while stalled");

  // a missing glyph carries zero atlas coordinates
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[65:34] == 32'd0)
    else $error("not_found command with nonzero source");

  // the final text word starts layout, input stalls
  a_final_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser && s_axis_tlast
    |=> !s_axis_tready)
    else $error("input taken right after final character");

  // more commands follow a non-last one, so layout is still busy
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
    else $error("input taken before text emission finished");

endmodule

bind bitmap_font_text_layout bftl_checker u_bftl_checker (.*);
